/* rtl/tfm_pkg.sv */
// Package: shared types and constants for the topic filter matcher.
`timescale 1ns / 1ps
package tfm_pkg;

  localparam int NUM_FILTERS_DEF    = 8;
  localparam int MAX_FILTER_LEN_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int OFFSET_W = 6;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int MASK_W   = 8;

  localparam logic [BYTE_W-1:0] SLASH_BYTE = 8'd47;
  localparam logic [BYTE_W-1:0] HASH_BYTE  = 8'd35;
  localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'd43;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILTER_BYTE = 2'd0,
    KIND_FILTER_LEN  = 2'd1,
    KIND_TOPIC_BYTE  = 2'd2,
    KIND_TOPIC_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_COMPARING = 2'd0,
    ST_FAILED    = 2'd1,
    ST_MATCHED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_PLUS    = 2'd2
  } seg_mode_t;

  // Per-slot control from the top level, one item per cycle while the input channel is ready.
  typedef struct packed {
    logic              topic_byte;
    logic              topic_end;
    logic [BYTE_W-1:0] data;
    logic              wr_en;
    logic [OFFSET_W-1:0] wr_offset;
  } slot_ctl_t;

endpackage

/* rtl/tfm_if.sv */
// Interfaces: input item channel and match result channel.
`timescale 1ns / 1ps
interface tfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [tfm_pkg::KIND_W-1:0]   kind;
  logic [tfm_pkg::SLOT_W-1:0]   filter_slot;
  logic [tfm_pkg::OFFSET_W-1:0] filter_offset;
  logic [tfm_pkg::BYTE_W-1:0]   data_byte;
  logic [tfm_pkg::LEN_W-1:0]    filter_length;

  modport source (output valid, kind, filter_slot, filter_offset, data_byte, filter_length,
                  input ready);
  modport sink (input valid, kind, filter_slot, filter_offset, data_byte, filter_length,
                output ready);
endinterface

interface tfm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       match_any;
  logic [tfm_pkg::MASK_W-1:0] match_mask;

  modport source (output valid, match_any, match_mask, input ready);
  modport sink (input valid, match_any, match_mask, output ready);
endinterface

/* rtl/tfm_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module tfm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/tfm_slot.sv */
// One filter slot: even/odd byte banks and the segment matching state.
`timescale 1ns / 1ps
module tfm_slot #(
  parameter int MAX_FILTER_LEN = tfm_pkg::MAX_FILTER_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tfm_pkg::slot_ctl_t        ctl,
  input  logic [tfm_pkg::LEN_W-1:0] len,
  output logic                      end_match
);
  localparam int EVEN_DEPTH = (MAX_FILTER_LEN + 1) / 2;
  localparam int ODD_DEPTH  = MAX_FILTER_LEN / 2;
  localparam int AW = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;

  logic [tfm_pkg::LEN_W-1:0] cursor_r, cursor_nxt;
  tfm_pkg::status_t          status_r, status_nxt;
  tfm_pkg::seg_mode_t        mode_r, mode_nxt;

  logic [tfm_pkg::LEN_W-1:0] e_pos, o_pos;
  logic [AW-1:0]             e_raddr, o_raddr, wr_addr;
  logic                      wr_even, wr_odd;
  logic [tfm_pkg::BYTE_W-1:0] e_rdata, o_rdata, e_byte, o_byte;
  logic                      fwd_e_r, fwd_o_r;
  logic [tfm_pkg::BYTE_W-1:0] fwd_data_r;
  logic [tfm_pkg::BYTE_W-1:0] b0, b1;
  logic [tfm_pkg::LEN_W:0]   c_ext, c1, len_ext;
  logic                      c_past_end, c1_past_end;
  logic                      one_hash, one_plus;
  tfm_pkg::seg_mode_t        eff_mode;

  // Bank addresses for bytes at cursor_nxt and cursor_nxt+1
  assign e_pos   = (cursor_nxt + 7'd1) >> 1;
  assign o_pos   = cursor_nxt >> 1;
  assign e_raddr = e_pos[AW-1:0];
  assign o_raddr = o_pos[AW-1:0];
  assign wr_addr = AW'(ctl.wr_offset >> 1);
  assign wr_even = ctl.wr_en && !ctl.wr_offset[0];
  assign wr_odd  = ctl.wr_en && ctl.wr_offset[0];

  tfm_ram #(.WIDTH(tfm_pkg::BYTE_W), .DEPTH(EVEN_DEPTH), .ADDR_W(AW)) u_even (
    .clk(clk), .we(wr_even), .waddr(wr_addr), .wdata(ctl.data),
    .raddr(e_raddr), .rdata(e_rdata)
  );
  tfm_ram #(.WIDTH(tfm_pkg::BYTE_W), .DEPTH(ODD_DEPTH), .ADDR_W(AW)) u_odd (
    .clk(clk), .we(wr_odd), .waddr(wr_addr), .wdata(ctl.data),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // Write to the address being read: forward the new byte
  always_ff @(posedge clk) begin
    fwd_e_r    <= wr_even && (wr_addr == e_raddr);
    fwd_o_r    <= wr_odd && (wr_addr == o_raddr);
    fwd_data_r <= ctl.data;
  end

  assign e_byte = fwd_e_r ? fwd_data_r : e_rdata;
  assign o_byte = fwd_o_r ? fwd_data_r : o_rdata;
  assign b0 = cursor_r[0] ? o_byte : e_byte;
  assign b1 = cursor_r[0] ? e_byte : o_byte;

  assign c_ext       = {1'b0, cursor_r};
  assign c1          = c_ext + 8'd1;
  assign len_ext     = {1'b0, len};
  assign c_past_end  = c_ext >= len_ext;
  assign c1_past_end = c1 >= len_ext;
  assign one_hash = (b0 == tfm_pkg::HASH_BYTE) && (c1_past_end || b1 == tfm_pkg::SLASH_BYTE);
  assign one_plus = (b0 == tfm_pkg::PLUS_BYTE) && (c1_past_end || b1 == tfm_pkg::SLASH_BYTE);

  always_comb begin
    case (mode_r)
      tfm_pkg::MODE_START:   end_match = c_past_end || one_hash;
      tfm_pkg::MODE_PLUS:    end_match = c1_past_end;
      default:               end_match = c_past_end;
    endcase
    case (status_r)
      tfm_pkg::ST_MATCHED: end_match = 1'b1;
      tfm_pkg::ST_FAILED:  end_match = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    cursor_nxt = cursor_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    eff_mode   = mode_r;
    if (ctl.topic_byte && status_r == tfm_pkg::ST_COMPARING) begin
      if (mode_r == tfm_pkg::MODE_START) begin
        if (c_past_end) begin
          status_nxt = tfm_pkg::ST_FAILED;
        end else if (one_hash) begin
          status_nxt = tfm_pkg::ST_MATCHED;
        end else begin
          eff_mode = one_plus ? tfm_pkg::MODE_PLUS : tfm_pkg::MODE_LITERAL;
        end
      end
      if (status_nxt == tfm_pkg::ST_COMPARING) begin
        mode_nxt = eff_mode;
        if (eff_mode == tfm_pkg::MODE_PLUS) begin
          if (ctl.data == tfm_pkg::SLASH_BYTE) begin
            if (c1_past_end) begin
              status_nxt = tfm_pkg::ST_FAILED;
            end else begin
              cursor_nxt = cursor_r + 7'd2;
              mode_nxt   = tfm_pkg::MODE_START;
            end
          end
        end else if (!c_past_end && b0 == ctl.data) begin
          cursor_nxt = cursor_r + 7'd1;
          if (ctl.data == tfm_pkg::SLASH_BYTE) begin
            mode_nxt = tfm_pkg::MODE_START;
          end
        end else begin
          status_nxt = tfm_pkg::ST_FAILED;
        end
      end
    end
    if (ctl.topic_end || !rst_n) begin
      cursor_nxt = '0;
      status_nxt = tfm_pkg::ST_COMPARING;
      mode_nxt   = tfm_pkg::MODE_START;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    status_r <= status_nxt;
    mode_r   <= mode_nxt;
  end
endmodule

/* rtl/topic_filter_matcher_top.sv */
// Top level: item decode, slot lengths, enable mask and result register.
`timescale 1ns / 1ps
// Takes one item per cycle, every kind, back to back; an end-of-topic item's
// result is registered and shows on the out channel the next cycle, and input
// keeps flowing while that register is empty or being drained. Each slot keeps
// its filter bytes in two RAM banks with registered reads (even and odd positions),
// so the byte at the cursor and the byte after it are read together, and the
// next cursor drives the read address, which holds one topic byte per cycle.
module topic_filter_matcher_top #(
  parameter int NUM_FILTERS    = tfm_pkg::NUM_FILTERS_DEF,
  parameter int MAX_FILTER_LEN = tfm_pkg::MAX_FILTER_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tfm_in_if.sink                       in_ch,
  tfm_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [tfm_pkg::MASK_W-1:0]   cfg_wdata
);
  logic [tfm_pkg::MASK_W-1:0] enable_r;
  logic [tfm_pkg::LEN_W-1:0]  len_r [NUM_FILTERS];
  logic                       out_valid_r;
  logic                       match_any_r;
  logic [tfm_pkg::MASK_W-1:0] match_mask_r, mask_nxt;
  logic                       xfer;
  logic                       slot_ok, off_ok;
  logic [tfm_pkg::LEN_W-1:0]  sat_len;
  logic [NUM_FILTERS-1:0]     end_hit;
  tfm_pkg::kind_t             kind;

  assign kind     = tfm_pkg::kind_t'(in_ch.kind);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer     = in_ch.valid && in_ch.ready;
  assign slot_ok  = {1'b0, in_ch.filter_slot} < 4'(NUM_FILTERS);
  assign off_ok   = {1'b0, in_ch.filter_offset} < 7'(MAX_FILTER_LEN);
  assign sat_len  = (in_ch.filter_length > 7'(MAX_FILTER_LEN)) ? 7'(MAX_FILTER_LEN)
                                                                : in_ch.filter_length;

  for (genvar i = 0; i < NUM_FILTERS; i++) begin : g_slot
    tfm_pkg::slot_ctl_t ctl;
    assign ctl.topic_byte = xfer && kind == tfm_pkg::KIND_TOPIC_BYTE;
    assign ctl.topic_end  = xfer && kind == tfm_pkg::KIND_TOPIC_END;
    assign ctl.data       = in_ch.data_byte;
    assign ctl.wr_en      = xfer && kind == tfm_pkg::KIND_FILTER_BYTE && off_ok
                            && in_ch.filter_slot == tfm_pkg::SLOT_W'(i);
    assign ctl.wr_offset  = in_ch.filter_offset;

    tfm_slot #(.MAX_FILTER_LEN(MAX_FILTER_LEN)) u_slot (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .len(len_r[i]), .end_match(end_hit[i])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        len_r[i] <= '0;
      end else if (xfer && kind == tfm_pkg::KIND_FILTER_LEN && slot_ok
                   && in_ch.filter_slot == tfm_pkg::SLOT_W'(i)) begin
        len_r[i] <= sat_len;
      end
    end
  end

  always_comb begin
    mask_nxt = '0;
    mask_nxt[NUM_FILTERS-1:0] = end_hit & enable_r[NUM_FILTERS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      if (xfer && kind == tfm_pkg::KIND_TOPIC_END) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && kind == tfm_pkg::KIND_TOPIC_END) begin
      match_mask_r <= mask_nxt;
      match_any_r  <= |mask_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_any  = match_any_r;
  assign out_ch.match_mask = match_mask_r;
endmodule

/* rtl/tfm_checker.sv */
// Port-level checker for the topic filter matcher, bound to the top level.
`timescale 1ns / 1ps
module tfm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [tfm_pkg::KIND_W-1:0]   in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_match_any,
  input logic [tfm_pkg::MASK_W-1:0]   out_match_mask
);
  logic end_xfer;
  assign end_xfer = in_valid && in_ready && in_kind == tfm_pkg::KIND_TOPIC_END;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    end_xfer |=> out_valid)
    else $error("end of topic transfer did not produce a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(end_xfer))
    else $error("result appeared without an end of topic transfer");

  a_any_is_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_any == (|out_match_mask)))
    else $error("match_any disagrees with match_mask");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_match_mask)))
    else $error("stalled result changed");
endmodule

bind topic_filter_matcher_top tfm_checker u_tfm_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_match_any(out_ch.match_any), .out_match_mask(out_ch.match_mask)
);
